[sv/rn7s_pkg.sv]
// Package for the radix number to seven-segment encoder.
// Holds shared widths, the digit glyph table, radix clamping and the divider control struct.
// Depends on nothing.
package rn7s_pkg;

    localparam int VALUE_W        = 32;
    localparam int RADIX_W        = 5;
    localparam int DIGIT_W        = 4;
    localparam int SEG_W          = 7;
    localparam int DIGITS_DEFAULT = 6;

    localparam logic [RADIX_W-1:0] RADIX_RESET = 5'd10;
    localparam logic [RADIX_W-1:0] RADIX_MIN   = 5'd2;
    localparam logic [RADIX_W-1:0] RADIX_MAX   = 5'd16;

    localparam logic [SEG_W-1:0] SEG_MINUS = 7'h40;
    localparam logic [SEG_W-1:0] SEG_BLANK = 7'h00;

    typedef struct packed {
        logic load;
        logic clr;
        logic step;
    } div_ctrl_t;

    function automatic logic [SEG_W-1:0] glyph(input logic [DIGIT_W-1:0] d);
        logic [SEG_W-1:0] s;
        begin
            unique case (d)
                4'h0:    s = 7'h3F;
                4'h1:    s = 7'h06;
                4'h2:    s = 7'h5B;
                4'h3:    s = 7'h4F;
                4'h4:    s = 7'h66;
                4'h5:    s = 7'h6D;
                4'h6:    s = 7'h7D;
                4'h7:    s = 7'h07;
                4'h8:    s = 7'h7F;
                4'h9:    s = 7'h6F;
                4'hA:    s = 7'h77;
                4'hB:    s = 7'h7C;
                4'hC:    s = 7'h39;
                4'hD:    s = 7'h5E;
                4'hE:    s = 7'h79;
                default: s = 7'h71;
            endcase
            return s;
        end
    endfunction

    function automatic logic [RADIX_W-1:0] clamp_radix(input logic [RADIX_W-1:0] r);
        logic [RADIX_W-1:0] b;
        begin
            if (r < RADIX_MIN) begin
                b = RADIX_MIN;
            end
            else if (r > RADIX_MAX) begin
                b = RADIX_MAX;
            end
            else begin
                b = r;
            end
            return b;
        end
    endfunction

endpackage

[sv/rn7s_serial_div.sv]
// Bit-serial restoring divider: one quotient bit per cycle while step is set, by a radix of at most 16.
// The dividend register shifts out its top bit and takes in the quotient bit.
// Depends on rn7s_pkg.
module rn7s_serial_div
(
    input  logic                               clk,
    input  rn7s_pkg::div_ctrl_t                ctrl,
    input  logic [rn7s_pkg::VALUE_W-1:0]       dividend,
    input  logic [rn7s_pkg::RADIX_W-1:0]       base,
    output logic [rn7s_pkg::VALUE_W-1:0]       quotient,
    output logic [rn7s_pkg::DIGIT_W-1:0]       remainder
);

    logic [rn7s_pkg::VALUE_W-1:0] quo_reg;
    logic [rn7s_pkg::VALUE_W-1:0] quo_next;
    logic [rn7s_pkg::DIGIT_W-1:0] rem_reg;
    logic [rn7s_pkg::DIGIT_W-1:0] rem_next;
    logic [rn7s_pkg::RADIX_W-1:0] trial;
    logic [rn7s_pkg::RADIX_W-1:0] diff;
    logic                         fits;

    assign trial = {rem_reg, quo_reg[rn7s_pkg::VALUE_W-1]};
    assign fits  = (trial >= base);
    assign diff  = trial - base;

    always_comb
    begin
        quo_next = quo_reg;
        rem_next = rem_reg;
        if (ctrl.load) begin
            quo_next = dividend;
            rem_next = '0;
        end
        else if (ctrl.clr) begin
            rem_next = '0;
        end
        else if (ctrl.step) begin
            quo_next = {quo_reg[rn7s_pkg::VALUE_W-2:0], fits};
            rem_next = fits ? diff[rn7s_pkg::DIGIT_W-1:0] : trial[rn7s_pkg::DIGIT_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
    end

    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

[sv/rn7s_out_stage.sv]
// Output register for one display word, with valid and stall toward the consumer.
// Load a new word only when the register is empty or its word is being taken; the block does not enforce it.
// Depends on rn7s_pkg.
module rn7s_out_stage #(
    parameter int DIGITS = rn7s_pkg::DIGITS_DEFAULT,
    parameter int POS_W  = $clog2(DIGITS + 1)
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        load,
    input  logic [POS_W-1:0]            position_in,
    input  logic [DIGITS-1:0]           select_in,
    input  logic [rn7s_pkg::SEG_W-1:0]  segments_in,
    input  logic                        overflow_in,
    input  logic                        last_in,
    output logic                        can_load,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [POS_W-1:0]            position,
    output logic [DIGITS-1:0]           select_pattern,
    output logic [rn7s_pkg::SEG_W-1:0]  segments,
    output logic                        overflow,
    output logic                        last
);

    logic                       valid_reg;
    logic                       valid_next;
    logic [POS_W-1:0]           pos_reg;
    logic [DIGITS-1:0]          sel_reg;
    logic [rn7s_pkg::SEG_W-1:0] seg_reg;
    logic                       ovf_reg;
    logic                       last_reg;

    assign can_load = !valid_reg || !out_stall;

    always_comb
    begin
        if (load) begin
            valid_next = 1'b1;
        end
        else if (out_stall) begin
            valid_next = valid_reg;
        end
        else begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            valid_reg <= 1'b0;
        end
        else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load) begin
            pos_reg  <= position_in;
            sel_reg  <= select_in;
            seg_reg  <= segments_in;
            ovf_reg  <= overflow_in;
            last_reg <= last_in;
        end
    end

    assign out_valid      = valid_reg;
    assign position       = pos_reg;
    assign select_pattern = sel_reg;
    assign segments       = seg_reg;
    assign overflow       = ovf_reg;
    assign last           = last_reg;

endmodule

[sv/radix_number_to_seven_segment_top.sv]
// Radix number to seven-segment encoder, top level: sequencer, digit shift register, output.
// For each digit the number is divided by the radix one quotient bit at a time and the
// remainder pushed into the digit shift register; then one word per digit is emitted.
// A new number is accepted only when the sequencer is back in idle.
// Reset clears the sequencer and output valid and sets the radix to ten.
// Depends on rn7s_pkg, rn7s_serial_div and rn7s_out_stage.
module radix_number_to_seven_segment_top #(
    parameter int DIGITS = rn7s_pkg::DIGITS_DEFAULT,
    parameter int POS_W  = $clog2(DIGITS + 1)
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [rn7s_pkg::RADIX_W-1:0]        radix,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic signed [rn7s_pkg::VALUE_W-1:0] value,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [POS_W-1:0]                    position,
    output logic [DIGITS-1:0]                   select_pattern,
    output logic [rn7s_pkg::SEG_W-1:0]          segments,
    output logic                                overflow,
    output logic                                last
);

    localparam int IDX_W  = (DIGITS > 1) ? $clog2(DIGITS) : 1;
    localparam int CNT_W  = POS_W;
    localparam int BIT_W  = $clog2(rn7s_pkg::VALUE_W);
    localparam int DSR_W  = DIGITS * rn7s_pkg::DIGIT_W;
    localparam logic [BIT_W-1:0] BIT_LAST = BIT_W'(rn7s_pkg::VALUE_W - 1);
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(DIGITS - 1);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_DIV  = 4'b0010,
        ST_PUSH = 4'b0100,
        ST_EMIT = 4'b1000
    } state_t;

    state_t                       state_reg;
    state_t                       state_next;
    logic [rn7s_pkg::RADIX_W-1:0] radix_reg;
    logic [BIT_W-1:0]             bit_cnt_reg;
    logic [BIT_W-1:0]             bit_cnt_next;
    logic [IDX_W-1:0]             dcnt_reg;
    logic [IDX_W-1:0]             dcnt_next;
    logic [CNT_W-1:0]             len_reg;
    logic [CNT_W-1:0]             len_next;
    logic [CNT_W-1:0]             len_after;
    logic                         neg_reg;
    logic                         neg_next;
    logic                         ovf_reg;
    logic                         ovf_next;
    logic                         qovf_reg;
    logic                         qovf_next;
    logic [DSR_W-1:0]             digits_reg;
    logic [DSR_W-1:0]             digits_next;

    logic                          accept;
    logic [rn7s_pkg::VALUE_W-1:0]  mag;
    rn7s_pkg::div_ctrl_t           div_ctrl;
    logic [rn7s_pkg::VALUE_W-1:0]  quotient;
    logic [rn7s_pkg::DIGIT_W-1:0]  remainder;
    logic [rn7s_pkg::RADIX_W-1:0]  base;

    logic                          can_load;
    logic                          load;
    logic [CNT_W-1:0]              k_ext;
    logic [IDX_W-1:0]              sel_shift;
    logic [POS_W-1:0]              pos_word;
    logic [DIGITS-1:0]             sel_word;
    logic [rn7s_pkg::SEG_W-1:0]    seg_word;
    logic                          last_word;

    assign cfg_ready = (state_reg == ST_IDLE);
    assign in_stall  = (state_reg != ST_IDLE);
    assign accept    = in_valid && !in_stall;
    assign mag       = value[rn7s_pkg::VALUE_W-1] ? (~value + 1'b1) : value;
    assign base      = rn7s_pkg::clamp_radix(radix_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            radix_reg <= rn7s_pkg::RADIX_RESET;
        end
        else if (cfg_valid && cfg_ready) begin
            radix_reg <= radix;
        end
    end

    assign len_after = (remainder != '0) ? CNT_W'(CNT_W'(dcnt_reg) + CNT_W'(1)) : len_reg;

    always_comb
    begin
        state_next   = state_reg;
        bit_cnt_next = bit_cnt_reg;
        dcnt_next    = dcnt_reg;
        len_next     = len_reg;
        neg_next     = neg_reg;
        ovf_next     = ovf_reg;
        qovf_next    = qovf_reg;
        digits_next  = digits_reg;
        div_ctrl     = '0;
        load         = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept) begin
                    div_ctrl.load = 1'b1;
                    neg_next      = value[rn7s_pkg::VALUE_W-1];
                    len_next      = CNT_W'(1);
                    bit_cnt_next  = '0;
                    dcnt_next     = '0;
                    state_next    = ST_DIV;
                end
            end
            ST_DIV:
            begin
                div_ctrl.step = 1'b1;
                bit_cnt_next  = BIT_W'(bit_cnt_reg + 1'b1);
                if (bit_cnt_reg == BIT_LAST) begin
                    state_next = ST_PUSH;
                end
            end
            ST_PUSH:
            begin
                div_ctrl.clr = 1'b1;
                digits_next  = DSR_W'({remainder, digits_reg} >> rn7s_pkg::DIGIT_W);
                len_next     = len_after;
                bit_cnt_next = '0;
                if (dcnt_reg == IDX_LAST) begin
                    qovf_next  = (quotient != '0);
                    ovf_next   = (quotient != '0) ||
                                 (neg_reg && (len_after >= CNT_W'(DIGITS)));
                    dcnt_next  = '0;
                    state_next = ST_EMIT;
                end
                else begin
                    dcnt_next  = IDX_W'(dcnt_reg + 1'b1);
                    state_next = ST_DIV;
                end
            end
            ST_EMIT:
            begin
                if (can_load) begin
                    load        = 1'b1;
                    digits_next = digits_reg >> rn7s_pkg::DIGIT_W;
                    if (dcnt_reg == IDX_LAST) begin
                        state_next = ST_IDLE;
                    end
                    else begin
                        dcnt_next = IDX_W'(dcnt_reg + 1'b1);
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg   <= ST_IDLE;
            bit_cnt_reg <= '0;
            dcnt_reg    <= '0;
            len_reg     <= '0;
            neg_reg     <= 1'b0;
            ovf_reg     <= 1'b0;
            qovf_reg    <= 1'b0;
        end
        else begin
            state_reg   <= state_next;
            bit_cnt_reg <= bit_cnt_next;
            dcnt_reg    <= dcnt_next;
            len_reg     <= len_next;
            neg_reg     <= neg_next;
            ovf_reg     <= ovf_next;
            qovf_reg    <= qovf_next;
        end
    end

    always_ff @(posedge clk)
    begin
        digits_reg <= digits_next;
    end

    // A digit shows when it lies within the number's length, or always once the digits overflow.
    assign k_ext     = CNT_W'(dcnt_reg);
    assign sel_shift = IDX_W'(IDX_LAST - dcnt_reg);
    assign pos_word  = POS_W'(POS_W'(DIGITS) - k_ext);
    assign sel_word  = ~(DIGITS'(1) << sel_shift);
    assign last_word = (dcnt_reg == IDX_LAST);

    always_comb
    begin
        if ((k_ext < len_reg) || qovf_reg) begin
            seg_word = rn7s_pkg::glyph(digits_reg[rn7s_pkg::DIGIT_W-1:0]);
        end
        else if (neg_reg && (k_ext == len_reg)) begin
            seg_word = rn7s_pkg::SEG_MINUS;
        end
        else begin
            seg_word = rn7s_pkg::SEG_BLANK;
        end
    end

    rn7s_serial_div u_div
    (
        .clk       (clk),
        .ctrl      (div_ctrl),
        .dividend  (mag),
        .base      (base),
        .quotient  (quotient),
        .remainder (remainder)
    );

    rn7s_out_stage #(
        .DIGITS (DIGITS),
        .POS_W  (POS_W)
    ) u_out (
        .clk            (clk),
        .rst_n          (rst_n),
        .load           (load),
        .position_in    (pos_word),
        .select_in      (sel_word),
        .segments_in    (seg_word),
        .overflow_in    (ovf_reg),
        .last_in        (last_word),
        .can_load       (can_load),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .position       (position),
        .select_pattern (select_pattern),
        .segments       (segments),
        .overflow       (overflow),
        .last           (last)
    );

    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == ST_DIV) && (dcnt_reg == '0) && (bit_cnt_reg == '0))
        else $error("Accepted number did not start the first digit division.");

    a_div_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV) && (bit_cnt_reg == BIT_LAST) |=> (state_reg == ST_PUSH))
        else $error("Digit division did not end after the last quotient bit.");

    a_qovf_flags: assert property (@(posedge clk) disable iff (!rst_n)
        qovf_reg |-> ovf_reg)
        else $error("Digits that do not fit were not flagged as overflow.");

    a_last_word_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT) && load && last_word |=> (state_reg == ST_IDLE))
        else $error("Sequencer did not return to idle after the final word.");

endmodule

[bench/display_word_checker.sv]
// Checker for the radix number to seven-segment encoder: watches the radix, number and display
// word channels, predicts the six display words of every accepted number and compares them.
// Depends on rn7s_pkg.
module display_word_checker
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_valid,
    input  logic                                cfg_ready,
    input  logic [rn7s_pkg::RADIX_W-1:0]        radix,
    input  logic                                in_valid,
    input  logic                                in_stall,
    input  logic signed [rn7s_pkg::VALUE_W-1:0] value,
    input  logic                                out_valid,
    input  logic                                out_stall,
    input  logic [2:0]                          position,
    input  logic [rn7s_pkg::DIGITS_DEFAULT-1:0] select_pattern,
    input  logic [rn7s_pkg::SEG_W-1:0]          segments,
    input  logic                                overflow,
    input  logic                                last,
    output int                                  errors,
    output int                                  pending
);

    localparam int NUM_DIGITS = rn7s_pkg::DIGITS_DEFAULT;
    localparam int MAX_REPORTS = 10;
    localparam logic [16*rn7s_pkg::SEG_W-1:0] GLYPHS = {
        7'h71, 7'h79, 7'h5E, 7'h39, 7'h7C, 7'h77, 7'h6F, 7'h7F,
        7'h07, 7'h7D, 7'h6D, 7'h66, 7'h4F, 7'h5B, 7'h06, 7'h3F
    };

    typedef struct packed {
        logic [2:0]                 position;
        logic [NUM_DIGITS-1:0]      select_pattern;
        logic [rn7s_pkg::SEG_W-1:0] segments;
        logic                       overflow;
        logic                       last;
    } display_word_t;

    logic [rn7s_pkg::RADIX_W-1:0] radix_setting;
    display_word_t                expected_words [$];

    task automatic predict_display_words(input logic [rn7s_pkg::VALUE_W-1:0] raw);
        logic                           negative;
        logic [rn7s_pkg::VALUE_W-1:0]   magnitude;
        logic [rn7s_pkg::VALUE_W-1:0]   rest;
        logic [rn7s_pkg::VALUE_W-1:0]   base;
        logic [NUM_DIGITS-1:0]          one_hot;
        logic                           too_wide;
        int                             len;
        int                             k;
        display_word_t                  w;
        begin
            negative = raw[rn7s_pkg::VALUE_W-1];
            magnitude = negative ? -raw : raw;
            if (radix_setting < 2)
                base = 2;
            else if (radix_setting > 16)
                base = 16;
            else
                base = radix_setting;
            len = 1;
            rest = magnitude / base;
            while (rest != 0)
            begin
                rest = rest / base;
                len++;
            end
            too_wide = (len > NUM_DIGITS) || (negative && len >= NUM_DIGITS);
            rest = magnitude;
            for (k = 0; k < NUM_DIGITS; k++)
            begin
                one_hot = '0;
                one_hot[NUM_DIGITS-k-1] = 1'b1;
                w.position = NUM_DIGITS - k;
                w.select_pattern = ~one_hot;
                if (k < len)
                begin
                    w.segments = GLYPHS[(rest % base) * rn7s_pkg::SEG_W +: rn7s_pkg::SEG_W];
                    rest = rest / base;
                end
                else if (negative && k == len)
                    w.segments = rn7s_pkg::SEG_MINUS;
                else
                    w.segments = rn7s_pkg::SEG_BLANK;
                w.overflow = too_wide;
                w.last = (k == NUM_DIGITS - 1);
                expected_words.push_back(w);
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        display_word_t want;
        display_word_t got;
        if (!rst_n)
        begin
            radix_setting = rn7s_pkg::RADIX_RESET;
            expected_words.delete();
            pending = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                radix_setting = radix;
            if (in_valid && !in_stall)
                predict_display_words(value);
            if (out_valid && !out_stall)
            begin
                got = {position, select_pattern, segments, overflow, last};
                if (expected_words.size() == 0)
                begin
                    errors++;
                    if (errors <= MAX_REPORTS)
                        $display("Unexpected word: pos %0d sel %b seg %h ovf %b last %b",
                                 got.position, got.select_pattern, got.segments,
                                 got.overflow, got.last);
                end
                else
                begin
                    want = expected_words.pop_front();
                    if (got !== want)
                    begin
                        errors++;
                        if (errors <= MAX_REPORTS)
                        begin
                            $display("Word mismatch: expected pos %0d sel %b seg %h ovf %b last %b",
                                     want.position, want.select_pattern, want.segments,
                                     want.overflow, want.last);
                            $display("               got pos %0d sel %b seg %h ovf %b last %b",
                                     got.position, got.select_pattern, got.segments,
                                     got.overflow, got.last);
                        end
                    end
                end
            end
            pending = expected_words.size();
        end
    end

endmodule

[bench/tb_radix_number_to_seven_segment_top.sv]
// Testbench top for radix_number_to_seven_segment_top: drives radix writes and numbers under
// several idle and stall mixes, and reports the verdict of display_word_checker.
// Depends on rn7s_pkg, display_word_checker and the encoder RTL.
module tb_radix_number_to_seven_segment_top;

    localparam int LIMIT = 500000;
    localparam int HOLD_CYCLES = 1500;
    localparam int DRAIN_CYCLES = 250;
    localparam int SEGMENT_ITEMS = 12;
    localparam int PRESSURE_ITEMS = 8;

    logic                                clk;
    logic                                rst_n;
    logic                                cfg_valid;
    logic                                cfg_ready;
    logic [rn7s_pkg::RADIX_W-1:0]        radix;
    logic                                in_valid;
    logic                                in_stall;
    logic signed [rn7s_pkg::VALUE_W-1:0] value;
    logic                                out_valid;
    logic                                out_stall;
    logic [2:0]                          position;
    logic [rn7s_pkg::DIGITS_DEFAULT-1:0] select_pattern;
    logic [rn7s_pkg::SEG_W-1:0]          segments;
    logic                                overflow;
    logic                                last;
    int                                  errors;
    int                                  pending;
    int                                  cycle_count;
    int                                  idle_pct;
    int                                  stall_pct;
    logic                                hold_active;
    event                                hold_go;

    radix_number_to_seven_segment_top uut
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .radix          (radix),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .value          (value),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .position       (position),
        .select_pattern (select_pattern),
        .segments       (segments),
        .overflow       (overflow),
        .last           (last)
    );

    display_word_checker chk
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .radix          (radix),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .value          (value),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .position       (position),
        .select_pattern (select_pattern),
        .segments       (segments),
        .overflow       (overflow),
        .last           (last),
        .errors         (errors),
        .pending        (pending)
    );

    initial
        clk = 1'b0;

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    always @(negedge clk)
        out_stall <= hold_active || ($urandom_range(99) < stall_pct);

    always
    begin
        @(hold_go);
        @(posedge clk);
        hold_active = 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_active = 1'b0;
    end

    initial
    begin
        cycle_count = 0;
        while (cycle_count < LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("CHECKS FAILED");
        $finish;
    end

    function automatic logic [rn7s_pkg::VALUE_W-1:0] pick_value(input int base);
        longint unsigned span;
        logic [rn7s_pkg::VALUE_W-1:0] magnitude;
        int mode;
        int n;
        begin
            mode = $urandom_range(9);
            n = $urandom_range(7, 1);
            span = 1;
            repeat (n) span = span * base;
            if (span > 64'hFFFF_FFFF)
                span = 64'hFFFF_FFFF;
            if (mode < 3)
                magnitude = $urandom;
            else if (mode < 8)
                magnitude = $urandom_range(span - 1, 0);
            else if (mode == 8)
                magnitude = $urandom_range(1) ? span : span - 1;
            else
                magnitude = $urandom_range(1) ? 32'h8000_0000 : 32'd0;
            if (mode >= 3 && $urandom_range(1))
                magnitude = -magnitude;
            return magnitude;
        end
    endfunction

    task automatic send_number(input logic [rn7s_pkg::VALUE_W-1:0] v);
        begin
            while ($urandom_range(99) < idle_pct)
            begin
                in_valid <= 1'b0;
                value <= $urandom;
                @(negedge clk);
            end
            in_valid <= 1'b1;
            value <= v;
            @(posedge clk);
            while (in_stall)
                @(posedge clk);
            @(negedge clk);
        end
    endtask

    task automatic wait_drained;
        begin
            in_valid <= 1'b0;
            while (pending != 0)
                @(negedge clk);
        end
    endtask

    task automatic set_radix(input logic [rn7s_pkg::RADIX_W-1:0] r);
        begin
            wait_drained();
            cfg_valid <= 1'b1;
            radix <= r;
            @(posedge clk);
            while (!cfg_ready)
                @(posedge clk);
            @(negedge clk);
            cfg_valid <= 1'b0;
        end
    endtask

    initial
    begin
        logic [rn7s_pkg::RADIX_W-1:0] r;
        int eff;
        int s;
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        radix = rn7s_pkg::RADIX_RESET;
        in_valid = 1'b0;
        value = '0;
        out_stall = 1'b0;
        hold_active = 1'b0;
        idle_pct = 0;
        stall_pct = 0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        set_radix(5'd10);
        send_number(0);
        send_number(1);
        send_number(-1);
        send_number(987654);
        send_number(123);
        send_number(-98765);
        send_number(-123456);
        send_number(1000000);
        send_number(32'h7FFF_FFFF);
        send_number(-32'sh7FFF_FFFF);
        send_number(32'h8000_0000);
        set_radix(5'd16);
        send_number(32'hAB_CDEF);
        send_number(-32'sh0F_FFFF);
        send_number(-32'shFF_FFFF);
        send_number(32'h7FFF_FFFF);
        set_radix(5'd2);
        send_number(63);
        send_number(-31);
        send_number(-32);
        send_number(64);
        set_radix(5'd0);
        send_number(5);
        set_radix(5'd31);
        send_number(32'hFE_DCBA);
        set_radix(5'd1);
        send_number(-2);
        set_radix(5'd17);
        send_number(32'h1_0000);

        set_radix(5'd10);
        -> hold_go;
        repeat (PRESSURE_ITEMS) send_number(pick_value(10));
        wait_drained();

        for (s = 0; s < 8; s++)
        begin
            case (s)
                0: r = 5'd10;
                1: r = 5'd2;
                2: r = 5'd16;
                3: r = 5'd0;
                4: r = 5'd31;
                5: r = 5'd1;
                6: r = 5'd17;
                default: r = $urandom_range(31);
            endcase
            set_radix(r);
            case (s % 4)
                0:
                begin
                    idle_pct = 0;
                    stall_pct = 0;
                end
                1:
                begin
                    idle_pct = 75;
                    stall_pct = 0;
                end
                2:
                begin
                    idle_pct = 0;
                    stall_pct = 75;
                end
                default:
                begin
                    idle_pct = 6;
                    stall_pct = 6;
                end
            endcase
            eff = (r < 2) ? 2 : (r > 16) ? 16 : r;
            repeat (SEGMENT_ITEMS) send_number(pick_value(eff));
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (errors == 0 && pending == 0)
        begin
            $display("ALL CHECKS PASSED");
        end
        else
        begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
